/* rtl/les_pkg.sv */
// ----------------------------------------------------------------------------
// les_pkg
// Shared types and constants for the LOOK elevator scheduler.
// ----------------------------------------------------------------------------
package les_pkg;

    localparam int unsigned LES_DEPTH = 64;

    localparam int unsigned LES_ID_W    = 16;
    localparam int unsigned LES_TRACK_W = 16;
    localparam int unsigned LES_TIME_W  = 32;

    typedef enum logic {
        FUNC_ADD   = 1'b0,
        FUNC_ISSUE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        STAT_ADDED   = 2'd0,
        STAT_DROPPED = 2'd1,
        STAT_ISSUED  = 2'd2,
        STAT_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // One table slot as kept in the request memory
    typedef struct packed {
        logic                   valid;
        logic [LES_ID_W-1:0]    id;
        logic [LES_TRACK_W-1:0] track;
        logic [LES_TIME_W-1:0]  stamp;
    } t_entry;

    localparam int unsigned LES_ENTRY_W = $bits(t_entry);

endpackage

/* rtl/les_ram.sv */
// ----------------------------------------------------------------------------
// les_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module les_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/look_elevator_scheduler.sv */
// ----------------------------------------------------------------------------
// look_elevator_scheduler
// LOOK elevator scheduler: request table in one RAM, scanned one slot a cycle.
// ----------------------------------------------------------------------------
// Result: the result strobe follows the scan and the finishing step, and busy
// is low again in that same cycle.
// Concurrency: one transaction at a time, as the single RAM read port walks
// every slot once per add or issue; start is taken only while idle.
// Reset: synchronous, active low; afterwards a clearing pass writes every
// slot empty while busy stays high. The receiver cannot stall.
// ----------------------------------------------------------------------------
module look_elevator_scheduler #(
    parameter int unsigned DEPTH = les_pkg::LES_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_func,
    input  logic [les_pkg::LES_ID_W-1:0]     i_request_id,
    input  logic [les_pkg::LES_TRACK_W-1:0]  i_request_track,
    input  logic [les_pkg::LES_TRACK_W-1:0]  i_head_track,
    input  logic [les_pkg::LES_TIME_W-1:0]   i_now_time,
    output logic                             o_valid,
    output logic [1:0]                       o_status,
    output logic [les_pkg::LES_ID_W-1:0]     o_issued_id,
    output logic [les_pkg::LES_TRACK_W-1:0]  o_issued_track,
    output logic [les_pkg::LES_TRACK_W-1:0]  o_seek_distance,
    output logic [les_pkg::LES_TIME_W-1:0]   o_finish_time,
    output logic                             o_sweep_down
);

    import les_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_state r_state, n_state;

    logic [CW-1:0]          r_cnt;
    logic                   r_pend;
    logic [AW-1:0]          r_pidx;

    logic                   r_func;
    logic [LES_ID_W-1:0]    r_id;
    logic [LES_TRACK_W-1:0] r_trk;
    logic [LES_TRACK_W-1:0] r_head;
    logic [LES_TIME_W-1:0]  r_now;
    logic [LES_TIME_W-1:0]  r_arrival;
    logic                   r_dir;

    logic                   r_free_found;
    logic [AW-1:0]          r_free_idx;

    logic                   r_up_found, r_dn_found;
    logic [AW-1:0]          r_up_idx, r_dn_idx;
    logic [LES_TRACK_W-1:0] r_up_dist, r_dn_dist;
    logic [LES_TIME_W-1:0]  r_up_age, r_dn_age;
    logic [LES_ID_W-1:0]    r_up_id, r_dn_id;
    logic [LES_TRACK_W-1:0] r_up_trk, r_dn_trk;

    logic                   r_valid;
    t_status                r_status;
    logic [LES_ID_W-1:0]    r_o_id;
    logic [LES_TRACK_W-1:0] r_o_trk;
    logic [LES_TRACK_W-1:0] r_o_dist;
    logic [LES_TIME_W-1:0]  r_o_fin;
    logic                   r_o_down;

    logic                   w_accept;
    logic                   w_scan_rd;
    logic                   w_ram_we;
    logic [AW-1:0]          w_waddr;
    t_entry                 w_wdata;
    t_entry                 w_rdata;
    logic [LES_ENTRY_W-1:0] w_rdata_raw;

    logic                   w_up_ok, w_dn_ok;
    logic [LES_TRACK_W-1:0] w_dist_up, w_dist_dn;
    logic [LES_TIME_W-1:0]  w_age;
    logic                   w_up_better, w_dn_better;

    logic                   w_ahead_found;
    logic                   w_pick_found;
    logic                   w_pick_up;
    logic [AW-1:0]          w_pick_idx;
    logic [LES_ID_W-1:0]    w_pick_id;
    logic [LES_TRACK_W-1:0] w_pick_trk;
    logic [LES_TRACK_W-1:0] w_pick_dist;

    assign busy      = (r_state != ST_IDLE);
    assign w_accept  = start && (r_state == ST_IDLE);
    assign w_scan_rd = (r_state == ST_SCAN) && (r_cnt != CW'(DEPTH));

    // ------------------------------------------------------------------
    // Request table
    // ------------------------------------------------------------------
    les_ram #(
        .WIDTH (LES_ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata = t_entry'(w_rdata_raw);

    // ------------------------------------------------------------------
    // Per-slot evaluation of the entry coming out of the RAM
    // ------------------------------------------------------------------
    always_comb begin
        w_up_ok   = w_rdata.valid && (w_rdata.track >= r_head);
        w_dn_ok   = w_rdata.valid && (w_rdata.track <= r_head);
        w_dist_up = w_rdata.track - r_head;
        w_dist_dn = r_head - w_rdata.track;
        w_age     = r_arrival - w_rdata.stamp;
        // strict compare keeps the lowest slot on a full tie
        w_up_better = w_up_ok && (!r_up_found || (w_dist_up < r_up_dist) ||
                      ((w_dist_up == r_up_dist) && (w_age > r_up_age)));
        w_dn_better = w_dn_ok && (!r_dn_found || (w_dist_dn < r_dn_dist) ||
                      ((w_dist_dn == r_dn_dist) && (w_age > r_dn_age)));
    end

    // ------------------------------------------------------------------
    // Final choice: ahead first, else reverse
    // ------------------------------------------------------------------
    always_comb begin
        w_ahead_found = r_dir ? r_dn_found : r_up_found;
        w_pick_found  = r_up_found || r_dn_found;
        w_pick_up     = r_dir ? (!r_dn_found && r_up_found) : r_up_found;
        w_pick_idx    = w_pick_up ? r_up_idx  : r_dn_idx;
        w_pick_id     = w_pick_up ? r_up_id   : r_dn_id;
        w_pick_trk    = w_pick_up ? r_up_trk  : r_dn_trk;
        w_pick_dist   = w_pick_up ? r_up_dist : r_dn_dist;
    end

    // ------------------------------------------------------------------
    // RAM write port: clearing pass, insert or remove
    // ------------------------------------------------------------------
    always_comb begin
        w_ram_we = 1'b0;
        w_waddr  = r_cnt[AW-1:0];
        w_wdata  = '0;
        unique case (r_state)
            ST_CLEAR: begin
                w_ram_we = 1'b1;
            end
            ST_FINISH: begin
                if (r_func == FUNC_ADD) begin
                    w_ram_we      = r_free_found;
                    w_waddr       = r_free_idx;
                    w_wdata.valid = 1'b1;
                    w_wdata.id    = r_id;
                    w_wdata.track = r_trk;
                    w_wdata.stamp = r_arrival;
                end else begin
                    w_ram_we = w_pick_found;
                    w_waddr  = w_pick_idx;
                end
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_cnt == CW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if ((r_cnt == CW'(DEPTH)) && !r_pend) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Scan counter and read pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= w_scan_rd;
            if (w_accept) begin
                r_cnt <= '0;
            end else if (w_scan_rd || (r_state == ST_CLEAR)) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (w_scan_rd) begin
            r_pidx <= r_cnt[AW-1:0];
        end
    end

    // Latch the transaction and track the best candidates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_found <= 1'b0;
            r_up_found   <= 1'b0;
            r_dn_found   <= 1'b0;
        end else if (w_accept) begin
            r_free_found <= 1'b0;
            r_up_found   <= 1'b0;
            r_dn_found   <= 1'b0;
        end else if (r_pend) begin
            if (!w_rdata.valid && !r_free_found) begin
                r_free_found <= 1'b1;
            end
            if (w_up_better) begin
                r_up_found <= 1'b1;
            end
            if (w_dn_better) begin
                r_dn_found <= 1'b1;
            end
        end

        if (w_accept) begin
            r_func <= i_func;
            r_id   <= i_request_id;
            r_trk  <= i_request_track;
            r_head <= i_head_track;
            r_now  <= i_now_time;
        end
        if (r_pend) begin
            if (!w_rdata.valid && !r_free_found) begin
                r_free_idx <= r_pidx;
            end
            if (w_up_better) begin
                r_up_idx  <= r_pidx;
                r_up_dist <= w_dist_up;
                r_up_age  <= w_age;
                r_up_id   <= w_rdata.id;
                r_up_trk  <= w_rdata.track;
            end
            if (w_dn_better) begin
                r_dn_idx  <= r_pidx;
                r_dn_dist <= w_dist_dn;
                r_dn_age  <= w_age;
                r_dn_id   <= w_rdata.id;
                r_dn_trk  <= w_rdata.track;
            end
        end
    end

    // Commit: arrival count, sweep direction, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arrival <= '0;
            r_dir     <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_FINISH);
            if (r_state == ST_FINISH) begin
                if ((r_func == FUNC_ADD) && r_free_found) begin
                    r_arrival <= r_arrival + 1'b1;
                end
                if ((r_func == FUNC_ISSUE) && w_pick_found && !w_ahead_found) begin
                    r_dir <= ~r_dir;
                end
            end
        end

        if (r_state == ST_FINISH) begin
            r_o_id   <= '0;
            r_o_trk  <= '0;
            r_o_dist <= '0;
            r_o_fin  <= '0;
            r_o_down <= r_dir;
            if (r_func == FUNC_ADD) begin
                r_status <= r_free_found ? STAT_ADDED : STAT_DROPPED;
            end else if (!w_pick_found) begin
                r_status <= STAT_EMPTY;
            end else begin
                r_status <= STAT_ISSUED;
                r_o_id   <= w_pick_id;
                r_o_trk  <= w_pick_trk;
                r_o_dist <= w_pick_dist;
                r_o_fin  <= r_now + LES_TIME_W'(w_pick_dist);
                r_o_down <= r_dir ^ !w_ahead_found;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_issued_id     = r_o_id;
    assign o_issued_track  = r_o_trk;
    assign o_seek_distance = r_o_dist;
    assign o_finish_time   = r_o_fin;
    assign o_sweep_down    = r_o_down;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while a transaction is still in progress");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == ST_FINISH)
        else $error("result strobe without a finishing step");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy && (r_cnt == '0))
        else $error("accepted transaction did not start a scan");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> ((r_state == ST_CLEAR) || (r_state == ST_FINISH)))
        else $error("table written during a scan");

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STAT_ISSUED)) |->
            ((o_issued_id == '0) && (o_seek_distance == '0) && (o_finish_time == '0)))
        else $error("issue fields not zero on a non-issue result");

endmodule

/* bench/les_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_checker
// Watches the command and result sides of the LOOK scheduler, keeps its own
// copy of the request table, predicts every result and compares it in order.
// ----------------------------------------------------------------------------
module les_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic                             i_func,
    input  logic [les_pkg::LES_ID_W-1:0]     i_request_id,
    input  logic [les_pkg::LES_TRACK_W-1:0]  i_request_track,
    input  logic [les_pkg::LES_TRACK_W-1:0]  i_head_track,
    input  logic [les_pkg::LES_TIME_W-1:0]   i_now_time,
    input  logic                             i_valid,
    input  logic [1:0]                       i_status,
    input  logic [les_pkg::LES_ID_W-1:0]     i_issued_id,
    input  logic [les_pkg::LES_TRACK_W-1:0]  i_issued_track,
    input  logic [les_pkg::LES_TRACK_W-1:0]  i_seek_distance,
    input  logic [les_pkg::LES_TIME_W-1:0]   i_finish_time,
    input  logic                             i_sweep_down,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked,
    output int                               o_issued,
    output int                               o_dropped,
    output int                               o_empty
);

    import les_pkg::*;

    typedef struct packed {
        t_status                status;
        logic [LES_ID_W-1:0]    id;
        logic [LES_TRACK_W-1:0] track;
        logic [LES_TRACK_W-1:0] seek;
        logic [LES_TIME_W-1:0]  finish;
        logic                   down;
    } t_outcome;

    t_entry               slot_tbl [LES_DEPTH];
    logic [LES_TIME_W-1:0] arrivals;
    logic                 sweep_down;
    t_outcome             outcome_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_issued     = 0;
        o_dropped    = 0;
        o_empty      = 0;
    end

    // Nearest pending slot on one side of the head; ties go to the oldest
    // stamp, then to the lowest index. Returns -1 when that side is empty.
    function automatic int nearest_slot(logic [LES_TRACK_W-1:0] head, logic down);
        int                    best;
        int                    i;
        logic [LES_TRACK_W-1:0] gap;
        logic [LES_TRACK_W-1:0] best_dist;
        logic [LES_TIME_W-1:0]  age;
        logic [LES_TIME_W-1:0]  best_age;
        best      = -1;
        best_dist = '0;
        best_age  = '0;
        for (i = 0; i < LES_DEPTH; i++) begin
            if (!slot_tbl[i].valid)
                continue;
            if (down) begin
                if (slot_tbl[i].track > head)
                    continue;
                gap = head - slot_tbl[i].track;
            end else begin
                if (slot_tbl[i].track < head)
                    continue;
                gap = slot_tbl[i].track - head;
            end
            age = arrivals - slot_tbl[i].stamp;
            if (best < 0 || gap < best_dist || (gap == best_dist && age > best_age)) begin
                best      = i;
                best_dist = gap;
                best_age  = age;
            end
        end
        return best;
    endfunction

    function automatic t_outcome schedule_step(
        logic                   func,
        logic [LES_ID_W-1:0]    rid,
        logic [LES_TRACK_W-1:0] rtrack,
        logic [LES_TRACK_W-1:0] head,
        logic [LES_TIME_W-1:0]  now
    );
        t_outcome r;
        int       slot;
        int       i;
        r    = '0;
        slot = -1;
        if (t_func'(func) == FUNC_ADD) begin
            for (i = 0; i < LES_DEPTH; i++)
                if (!slot_tbl[i].valid && slot < 0)
                    slot = i;
            if (slot < 0) begin
                r.status = STAT_DROPPED;
            end else begin
                slot_tbl[slot].valid = 1'b1;
                slot_tbl[slot].id    = rid;
                slot_tbl[slot].track = rtrack;
                slot_tbl[slot].stamp = arrivals;
                arrivals             = arrivals + 1;
                r.status             = STAT_ADDED;
            end
        end else begin
            slot = nearest_slot(head, sweep_down);
            // nothing ahead: reverse and look the other way
            if (slot < 0) begin
                slot = nearest_slot(head, !sweep_down);
                if (slot >= 0)
                    sweep_down = !sweep_down;
            end
            if (slot < 0) begin
                r.status = STAT_EMPTY;
            end else begin
                slot_tbl[slot].valid = 1'b0;
                r.status = STAT_ISSUED;
                r.id     = slot_tbl[slot].id;
                r.track  = slot_tbl[slot].track;
                r.seek   = (r.track >= head) ? r.track - head : head - r.track;
                r.finish = now + LES_TIME_W'(r.seek);
            end
        end
        r.down = sweep_down;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome exp_r;
        t_outcome act_r;
        int       i;
        if (!i_rst_n) begin
            for (i = 0; i < LES_DEPTH; i++)
                slot_tbl[i] = '0;
            arrivals   = '0;
            sweep_down = 1'b0;
            outcome_q.delete();
        end else begin
            if (i_valid === 1'b1) begin
                act_r.status = t_status'(i_status);
                act_r.id     = i_issued_id;
                act_r.track  = i_issued_track;
                act_r.seek   = i_seek_distance;
                act_r.finish = i_finish_time;
                act_r.down   = i_sweep_down;
                if (outcome_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("[%0t] unexpected result: status=%0d id=%h track=%h",
                                 $realtime, i_status, i_issued_id, i_issued_track);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = outcome_q.pop_front();
                    o_checked <= o_checked + 1;
                    case (exp_r.status)
                        STAT_ISSUED:  o_issued  <= o_issued + 1;
                        STAT_DROPPED: o_dropped <= o_dropped + 1;
                        STAT_EMPTY:   o_empty   <= o_empty + 1;
                        default: ;
                    endcase
                    if (act_r !== exp_r) begin
                        if (o_fail_count < 10) begin
                            $display("[%0t] mismatch on transaction %0d", $realtime,
                                     o_checked);
                            $display("    expected: status=%0d id=%h track=%h seek=%h fin=%h dn=%b",
                                     exp_r.status, exp_r.id, exp_r.track, exp_r.seek,
                                     exp_r.finish, exp_r.down);
                            $display("    actual:   status=%0d id=%h track=%h seek=%h fin=%h dn=%b",
                                     i_status, i_issued_id, i_issued_track,
                                     i_seek_distance, i_finish_time, i_sweep_down);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0)
                outcome_q = {outcome_q, schedule_step(i_func, i_request_id, i_request_track,
                                                      i_head_track, i_now_time)};
        end
        o_pending <= outcome_q.size();
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives add and issue commands into the LOOK scheduler: a directed opening,
// then waves that fill, drain or mix the table with clustered tracks.
// ----------------------------------------------------------------------------
module tb_top;
    import les_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 1600;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_func;
    logic [LES_ID_W-1:0]     i_request_id;
    logic [LES_TRACK_W-1:0]  i_request_track;
    logic [LES_TRACK_W-1:0]  i_head_track;
    logic [LES_TIME_W-1:0]   i_now_time;
    logic                    o_valid;
    logic [1:0]              o_status;
    logic [LES_ID_W-1:0]     o_issued_id;
    logic [LES_TRACK_W-1:0]  o_issued_track;
    logic [LES_TRACK_W-1:0]  o_seek_distance;
    logic [LES_TIME_W-1:0]   o_finish_time;
    logic                    o_sweep_down;

    int fail_count;
    int pending;
    int checked;
    int issued;
    int dropped;
    int empty_hits;
    int cycles;
    int burst_left;
    int sent;
    logic [LES_TRACK_W-1:0] recent_tracks [8];

    look_elevator_scheduler DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_request_id    (i_request_id),
        .i_request_track (i_request_track),
        .i_head_track    (i_head_track),
        .i_now_time      (i_now_time),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_issued_id     (o_issued_id),
        .o_issued_track  (o_issued_track),
        .o_seek_distance (o_seek_distance),
        .o_finish_time   (o_finish_time),
        .o_sweep_down    (o_sweep_down)
    );

    les_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_func          (i_func),
        .i_request_id    (i_request_id),
        .i_request_track (i_request_track),
        .i_head_track    (i_head_track),
        .i_now_time      (i_now_time),
        .i_valid         (o_valid),
        .i_status        (o_status),
        .i_issued_id     (o_issued_id),
        .i_issued_track  (o_issued_track),
        .i_seek_distance (o_seek_distance),
        .i_finish_time   (o_finish_time),
        .i_sweep_down    (o_sweep_down),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_issued        (issued),
        .o_dropped       (dropped),
        .o_empty         (empty_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Hold the command until the block takes it.
    task automatic send_request(
        input t_func                  f,
        input logic [LES_ID_W-1:0]    rid,
        input logic [LES_TRACK_W-1:0] rtrack,
        input logic [LES_TRACK_W-1:0] head,
        input logic [LES_TIME_W-1:0]  now
    );
        start           <= 1'b1;
        i_func          <= f;
        i_request_id    <= rid;
        i_request_track <= rtrack;
        i_head_track    <= head;
        i_now_time      <= now;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        if (f == FUNC_ADD)
            recent_tracks[sent % 8] = rtrack;
        sent++;
    endtask

    // Bursts of back-to-back commands separated by idle gaps.
    task automatic pace();
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 90)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 6);
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic [LES_TRACK_W-1:0] pick_track(
        logic [LES_TRACK_W-1:0] center,
        int                     spread
    );
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return LES_TRACK_W'($urandom);
        if (sel < 7)
            return recent_tracks[$urandom_range(0, 7)];
        return center + LES_TRACK_W'($urandom_range(0, spread));
    endfunction

    initial begin
        t_func                  f;
        int                     mode;
        int                     wave_len;
        int                     add_pct;
        int                     spread;
        int                     k;
        logic [LES_TRACK_W-1:0] center;
        logic [LES_ID_W-1:0]    rid;
        logic [LES_TIME_W-1:0]  now;

        start           <= 1'b0;
        i_rst_n         <= 1'b0;
        i_func          <= FUNC_ADD;
        i_request_id    <= '0;
        i_request_track <= '0;
        i_head_track    <= '0;
        i_now_time      <= '0;
        burst_left = 0;
        sent       = 0;
        for (k = 0; k < 8; k++)
            recent_tracks[k] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening: empty table, extremes, ties, reversals, wrap
        send_request(FUNC_ISSUE, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000); pace();
        send_request(FUNC_ADD,   16'h0000, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF); pace();
        send_request(FUNC_ADD,   16'hFFFF, 16'hFFFF, 16'h0000, 32'h0000_0000); pace();
        send_request(FUNC_ADD,   16'h1234, 16'd100,  16'h0000, 32'h0000_0000); pace();
        send_request(FUNC_ADD,   16'h0002, 16'd100,  16'h0000, 32'h0000_0000); pace();
        send_request(FUNC_ISSUE, 16'hFFFF, 16'hFFFF, 16'd100,  32'hFFFF_FFFF); pace();
        send_request(FUNC_ISSUE, 16'h0000, 16'h0000, 16'd100,  32'hFFFF_FFF0); pace();
        send_request(FUNC_ISSUE, 16'h0000, 16'h0000, 16'd100,  32'hFFFF_FFFF); pace();
        send_request(FUNC_ISSUE, 16'h0000, 16'h0000, 16'hFFFF, 32'hFFFF_0000); pace();
        send_request(FUNC_ISSUE, 16'h0000, 16'h0000, 16'h8000, 32'h0000_0001); pace();
        send_request(FUNC_ADD,   16'h00A0, 16'd50,   16'h0000, 32'h0000_0000); pace();
        send_request(FUNC_ADD,   16'h00B0, 16'd150,  16'h0000, 32'h0000_0000); pace();
        send_request(FUNC_ISSUE, 16'h0000, 16'h0000, 16'd100,  32'h8000_0000); pace();
        send_request(FUNC_ISSUE, 16'h0000, 16'h0000, 16'd100,  32'h7FFF_FFFF); pace();
        send_request(FUNC_ADD,   16'h0301, 16'd300,  16'h0000, 32'h0000_0000); pace();
        send_request(FUNC_ADD,   16'h0302, 16'd300,  16'h0000, 32'h0000_0000); pace();
        send_request(FUNC_ADD,   16'h0303, 16'd300,  16'h0000, 32'h0000_0000); pace();
        send_request(FUNC_ADD,   16'h0200, 16'd200,  16'h0000, 32'h0000_0000); pace();
        send_request(FUNC_ADD,   16'h0400, 16'd400,  16'h0000, 32'h0000_0000); pace();
        send_request(FUNC_ISSUE, 16'h0000, 16'h0000, 16'd300,  32'h0000_1000); pace();
        send_request(FUNC_ISSUE, 16'h0000, 16'h0000, 16'd300,  32'h0000_1000); pace();
        send_request(FUNC_ISSUE, 16'h0000, 16'h0000, 16'd350,  32'h0000_1000); pace();
        send_request(FUNC_ISSUE, 16'h0000, 16'h0000, 16'd500,  32'h0000_1000); pace();
        send_request(FUNC_ISSUE, 16'h0000, 16'h0000, 16'd0,    32'h0000_1000); pace();

        // waves: fill the table past full, drain it past empty, or mix
        while (sent < RANDOM_ITEMS + 24) begin
            mode     = $urandom_range(0, 2);
            wave_len = $urandom_range(10, 90);
            center   = LES_TRACK_W'($urandom);
            case ($urandom_range(0, 3))
                0:       spread = 0;
                1:       spread = 3;
                2:       spread = 15;
                default: spread = 255;
            endcase
            add_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            for (k = 0; k < wave_len; k++) begin
                f   = ($urandom_range(0, 99) < add_pct) ? FUNC_ADD : FUNC_ISSUE;
                rid = ($urandom_range(0, 9) == 0) ? {LES_ID_W{$urandom_range(0, 1) == 1}}
                                                  : LES_ID_W'($urandom);
                case ($urandom_range(0, 19))
                    0, 1, 2: now = 32'hFFFF_FFFF - $urandom_range(0, 70000);
                    3:       now = $urandom_range(0, 255);
                    default: now = $urandom;
                endcase
                send_request(f, rid, pick_track(center, spread), pick_track(center, spread),
                             now);
                pace();
            end
        end
        start <= 1'b0;

        // drain outstanding results, then give stray strobes a chance
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (LES_DEPTH + 8) @(posedge i_clk);

        $display("%0d commands sent, %0d results checked: %0d issued, %0d added",
                 sent, checked, issued, checked - issued - dropped - empty_hits);
        $display("%0d adds dropped on a full table, %0d issues found it empty",
                 dropped, empty_hits);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d failures", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* look_elevator_scheduler.f */
rtl/les_pkg.sv
rtl/les_ram.sv
rtl/look_elevator_scheduler.sv
bench/les_checker.sv
bench/tb_top.sv
